// File: rtl/core/aps_pkg.sv
// shared types and constants for the aging priority scheduler
`default_nettype none
package aps_pkg;

    localparam int NUM_SLOTS_DEF = 16;

    localparam int CMD_W  = 2;
    localparam int SLOT_W = 4;
    localparam int PRI_W  = 8;
    localparam int AGE_W  = 8;
    localparam int ST_W   = 3;
    localparam int SUM_W  = 9;

    localparam int IN_BITS  = CMD_W + SLOT_W + PRI_W + ST_W;
    localparam int IN_W     = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_BITS = 1 + SLOT_W + SLOT_W;
    localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

    localparam logic [AGE_W-1:0] AGE_MAX = '1;

    // command codes
    localparam logic [CMD_W-1:0] CMD_TICK    = 2'd0;
    localparam logic [CMD_W-1:0] CMD_SET_PRI = 2'd1;
    localparam logic [CMD_W-1:0] CMD_SET_ST  = 2'd2;

    // slot status codes
    localparam logic [ST_W-1:0] ST_CREATED    = 3'd0;
    localparam logic [ST_W-1:0] ST_READY      = 3'd1;
    localparam logic [ST_W-1:0] ST_EXECUTING  = 3'd2;
    localparam logic [ST_W-1:0] ST_WAITING    = 3'd3;
    localparam logic [ST_W-1:0] ST_TERMINATED = 3'd4;

    // broadcast from the controller to every cell
    typedef struct packed {
        logic             commit;   // apply the outcome of a tick
        logic             found;    // tick picked a slot
        logic             wr_pri;   // write priority of the addressed slot
        logic             wr_st;    // write status of the addressed slot
        logic [PRI_W-1:0] pri;
        logic [ST_W-1:0]  st;
    } t_cell_ctl;

endpackage
`default_nettype wire

// File: rtl/core/aging_priority_scheduler_top.sv
// top level of the aging priority scheduler: command intake, search timing and result register
`default_nettype none
// Aging priority scheduler. Each request carries a command: a scheduling tick,
// a priority write or a status write for one task slot. Every request yields
// exactly one response {dispatched, next_slot, prev_slot}. Slots live in a row
// of NUM_SLOTS cells; a running best record (found, index, priority+age) is
// registered in each cell and passed to the next one every cycle, so the
// winner of a tick is known once the record has passed through every cell.
// Timing: the response to a priority or status write is registered as the
// write is accepted; a tick's response is registered once the record has
// crossed the cell row. One request is in work at a time; a new request is
// taken once the previous response has been delivered or is being taken.
// Ties go to the lowest slot index, ages saturate at 255, and a tick with no
// eligible slot (all waiting or terminated) reports dispatched = 0 and leaves
// every status and the running slot unchanged. Writes to a slot index at or
// beyond NUM_SLOTS, and status codes above terminated, are dropped.
module aging_priority_scheduler_top #(
    parameter int NUM_SLOTS = aps_pkg::NUM_SLOTS_DEF
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    // fields from bit 0: cmd[1:0], slot[5:2], priority_req[13:6], new_status[16:14]
    input  wire logic [aps_pkg::IN_W-1:0]  s_axis_tdata,
    input  wire logic                      s_axis_tvalid,
    output logic                           s_axis_tready,
    // fields from bit 0: dispatched[0], next_slot[4:1], prev_slot[8:5]
    output logic [aps_pkg::OUT_W-1:0]      m_axis_tdata,
    output logic                           m_axis_tvalid,
    input  wire logic                      m_axis_tready
);

    localparam int IDX_W = $clog2(NUM_SLOTS);
    localparam int CNT_W = $clog2(NUM_SLOTS);
    localparam int CMP_W = ((IDX_W > aps_pkg::SLOT_W) ? IDX_W : aps_pkg::SLOT_W) + 1;
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(NUM_SLOTS - 1);

    typedef enum logic {
        S_IDLE,
        S_SCAN
    } t_state;

    // request fields
    logic [aps_pkg::CMD_W-1:0]  w_cmd;
    logic [aps_pkg::SLOT_W-1:0] w_slot;
    logic [aps_pkg::PRI_W-1:0]  w_pri;
    logic [aps_pkg::ST_W-1:0]   w_st;

    assign w_cmd  = s_axis_tdata[1:0];
    assign w_slot = s_axis_tdata[5:2];
    assign w_pri  = s_axis_tdata[13:6];
    assign w_st   = s_axis_tdata[16:14];

    t_state                    r_state;
    logic [CNT_W-1:0]          r_cnt;
    logic [IDX_W-1:0]          r_run;
    logic                      r_out_valid;
    logic [aps_pkg::OUT_W-1:0] r_out_data;

    // search chain wiring, stage 0 is the empty record
    logic                      w_found [NUM_SLOTS+1];
    logic [IDX_W-1:0]          w_idx   [NUM_SLOTS+1];
    logic [aps_pkg::SUM_W-1:0] w_sum   [NUM_SLOTS+1];

    logic               w_out_free;
    logic               w_req;
    logic               w_slot_ok;
    logic               w_commit;
    logic               w_reply;
    logic               w_best_found;
    logic [IDX_W-1:0]   w_best;
    aps_pkg::t_cell_ctl w_ctl;

    assign w_out_free    = !r_out_valid || m_axis_tready;
    assign s_axis_tready = (r_state == S_IDLE) && w_out_free;
    assign w_req         = s_axis_tvalid && s_axis_tready;
    assign w_slot_ok     = CMP_W'(w_slot) < CMP_W'(NUM_SLOTS);

    // tick result is read off the end of the row once it has settled
    assign w_commit     = (r_state == S_SCAN) && (r_cnt == CNT_LAST) && w_out_free;
    assign w_best_found = w_found[NUM_SLOTS];
    assign w_best       = w_idx[NUM_SLOTS];

    // a response is loaded for every write at once and for a tick at commit
    assign w_reply = (w_req && (w_cmd != aps_pkg::CMD_TICK)) || w_commit;

    always_comb begin
        w_ctl        = '0;
        w_ctl.commit = w_commit;
        w_ctl.found  = w_best_found;
        w_ctl.wr_pri = w_req && (w_cmd == aps_pkg::CMD_SET_PRI) && w_slot_ok;
        w_ctl.wr_st  = w_req && (w_cmd == aps_pkg::CMD_SET_ST) && w_slot_ok
                       && (w_st <= aps_pkg::ST_TERMINATED);
        w_ctl.pri    = w_pri;
        w_ctl.st     = w_st;
    end

    assign w_found[0] = 1'b0;
    assign w_idx[0]   = '0;
    assign w_sum[0]   = '0;

    for (genvar g = 0; g < NUM_SLOTS; g++) begin : g_cell
        aps_cell #(
            .IDX_W (IDX_W),
            .IDX   (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (w_ctl),
            .i_addr  (IDX_W'(w_slot)),
            .i_best  (w_best),
            .i_prev  (r_run),
            .i_found (w_found[g]),
            .i_idx   (w_idx[g]),
            .i_sum   (w_sum[g]),
            .o_found (w_found[g+1]),
            .o_idx   (w_idx[g+1]),
            .o_sum   (w_sum[g+1])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_run       <= '0;
            r_out_valid <= 1'b0;
            r_out_data  <= '0;
        end else begin
            if (w_reply) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_req) begin
                        if (w_cmd == aps_pkg::CMD_TICK) begin
                            r_state <= S_SCAN;
                            r_cnt   <= '0;
                        end else begin
                            // writes and the unused code answer at once
                            r_out_data  <= aps_pkg::OUT_W'({aps_pkg::SLOT_W'(r_run),
                                                            aps_pkg::SLOT_W'(0), 1'b0});
                        end
                    end
                end
                S_SCAN: begin
                    if (r_cnt != CNT_LAST) begin
                        r_cnt <= r_cnt + 1'b1;
                    end else if (w_commit) begin
                        r_state     <= S_IDLE;
                        if (w_best_found) begin
                            r_run      <= w_best;
                            r_out_data <= aps_pkg::OUT_W'({aps_pkg::SLOT_W'(r_run),
                                                           aps_pkg::SLOT_W'(w_best), 1'b1});
                        end else begin
                            r_out_data <= aps_pkg::OUT_W'({aps_pkg::SLOT_W'(r_run),
                                                           aps_pkg::SLOT_W'(0), 1'b0});
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

endmodule
`default_nettype wire

// File: rtl/core/aps_cell.sv
// one task slot: holds priority, age and status, and one stage of the search chain
`default_nettype none
module aps_cell #(
    parameter int IDX_W = 4,
    parameter int IDX   = 0
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire aps_pkg::t_cell_ctl          i_ctl,
    input  wire logic [IDX_W-1:0]            i_addr,
    input  wire logic [IDX_W-1:0]            i_best,
    input  wire logic [IDX_W-1:0]            i_prev,
    input  wire logic                        i_found,
    input  wire logic [IDX_W-1:0]            i_idx,
    input  wire logic [aps_pkg::SUM_W-1:0]   i_sum,
    output logic                             o_found,
    output logic [IDX_W-1:0]                 o_idx,
    output logic [aps_pkg::SUM_W-1:0]        o_sum
);

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(IDX);

    logic [aps_pkg::PRI_W-1:0] r_pri;
    logic [aps_pkg::AGE_W-1:0] r_age;
    logic [aps_pkg::ST_W-1:0]  r_st;
    logic [aps_pkg::PRI_W-1:0] n_pri;
    logic [aps_pkg::AGE_W-1:0] n_age;
    logic [aps_pkg::ST_W-1:0]  n_st;

    logic                      r_found;
    logic [IDX_W-1:0]          r_idx;
    logic [aps_pkg::SUM_W-1:0] r_sum;

    logic [aps_pkg::SUM_W-1:0] w_sum;
    logic                      w_elig;
    logic                      w_take;

    assign w_sum  = {1'b0, r_pri} + {1'b0, r_age};
    assign w_elig = (r_st != aps_pkg::ST_WAITING) && (r_st != aps_pkg::ST_TERMINATED);
    assign w_take = w_elig && (!i_found || (w_sum > i_sum));

    always_comb begin
        n_pri = r_pri;
        n_age = r_age;
        n_st  = r_st;
        if (i_ctl.commit) begin
            if (r_age != aps_pkg::AGE_MAX) begin
                n_age = r_age + 1'b1;
            end
            if (i_ctl.found) begin
                if (MY_IDX == i_best) begin
                    n_age = '0;
                    n_st  = aps_pkg::ST_EXECUTING;
                end else if ((MY_IDX == i_prev) && (r_st == aps_pkg::ST_EXECUTING)) begin
                    n_st  = aps_pkg::ST_READY;
                end
            end
        end
        if (i_ctl.wr_pri && (i_addr == MY_IDX)) begin
            n_pri = i_ctl.pri;
        end
        if (i_ctl.wr_st && (i_addr == MY_IDX)) begin
            n_st = i_ctl.st;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pri   <= '0;
            r_age   <= '0;
            r_st    <= aps_pkg::ST_TERMINATED;
            r_found <= 1'b0;
            r_idx   <= '0;
            r_sum   <= '0;
        end else begin
            r_pri   <= n_pri;
            r_age   <= n_age;
            r_st    <= n_st;
            r_found <= i_found || w_take;
            r_idx   <= w_take ? MY_IDX : i_idx;
            r_sum   <= w_take ? w_sum : i_sum;
        end
    end

    assign o_found = r_found;
    assign o_idx   = r_idx;
    assign o_sum   = r_sum;

endmodule
`default_nettype wire

// File: verif/testbench.sv
// self-checking testbench for the aging priority scheduler: directed table, then random traffic
module testbench;
    import aps_pkg::*;

    localparam int SLOTS          = NUM_SLOTS_DEF;
    localparam int TICK_LATENCY   = SLOTS + 1;
    localparam int CYCLE_LIMIT    = 300000;
    localparam int SQUEEZE_CYCLES = 300;
    localparam int MIXED_RUN      = 83;
    localparam int AGING_TICKS    = 256;
    localparam int REPORT_MAX     = 10;

    // command code with no function, status codes past terminated
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
    localparam logic [ST_W-1:0]  ST_BAD_LO  = 3'd5;
    localparam logic [ST_W-1:0]  ST_BAD_HI  = 3'd7;

    localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(SLOTS - 1);
    localparam logic [PRI_W-1:0]  PRI_TOP   = '1;

    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic [SLOT_W-1:0] slot;
        logic [PRI_W-1:0]  pri;
        logic [ST_W-1:0]   st;
    } sched_req_t;

    typedef struct packed {
        logic              dispatched;
        logic [SLOT_W-1:0] next_slot;
        logic [SLOT_W-1:0] prev_slot;
    } sched_reply_t;

    // one line of the directed table; typed rows carry a hand-written reply
    typedef struct packed {
        sched_req_t   req;
        logic         typed;
        sched_reply_t reply;
    } plan_row_t;

    logic               i_clk         = 1'b0;
    logic               i_rst_n       = 1'b0;
    logic [IN_W-1:0]    s_axis_tdata  = '0;
    logic               s_axis_tvalid = 1'b0;
    logic               s_axis_tready;
    logic [OUT_W-1:0]   m_axis_tdata;
    logic               m_axis_tvalid;
    logic               m_axis_tready = 1'b0;

    // scheduler image kept by the testbench
    logic [PRI_W-1:0]   pri_tbl [SLOTS];
    logic [AGE_W-1:0]   age_tbl [SLOTS];
    logic [ST_W-1:0]    st_tbl  [SLOTS];
    logic [SLOT_W-1:0]  running;

    sched_reply_t       replies_due [$];
    int unsigned        requests_taken = 0;
    int unsigned        replies_seen   = 0;
    int unsigned        mismatches     = 0;
    int unsigned        cycle_count    = 0;

    aging_priority_scheduler_top uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d replies outstanding",
                     cycle_count, replies_due.size());
            $display("DONE: errors detected");
            $finish;
        end
    end

    // mostly short pauses, now and then a long one
    function automatic int unsigned idle_len();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 50)
            return 0;
        else if (pick < 85)
            return $urandom_range(1, 3);
        else if (pick < 97)
            return $urandom_range(4, 10);
        else
            return $urandom_range(20, 40);
    endfunction

    function automatic sched_req_t make_req(input logic [CMD_W-1:0] cmd,
                                            input logic [SLOT_W-1:0] slot,
                                            input logic [PRI_W-1:0] pri,
                                            input logic [ST_W-1:0] st);
        sched_req_t r;
        r.cmd  = cmd;
        r.slot = slot;
        r.pri  = pri;
        r.st   = st;
        return r;
    endfunction

    function automatic plan_row_t checked(input logic [CMD_W-1:0] cmd,
                                          input logic [SLOT_W-1:0] slot,
                                          input logic [PRI_W-1:0] pri,
                                          input logic [ST_W-1:0] st);
        plan_row_t row;
        row.req   = make_req(cmd, slot, pri, st);
        row.typed = 1'b0;
        row.reply = '0;
        return row;
    endfunction

    function automatic plan_row_t known(input logic [CMD_W-1:0] cmd,
                                        input logic [SLOT_W-1:0] slot,
                                        input logic [PRI_W-1:0] pri,
                                        input logic [ST_W-1:0] st,
                                        input logic dispatched,
                                        input logic [SLOT_W-1:0] next_slot,
                                        input logic [SLOT_W-1:0] prev_slot);
        plan_row_t row;
        row.req              = make_req(cmd, slot, pri, st);
        row.typed            = 1'b1;
        row.reply.dispatched = dispatched;
        row.reply.next_slot  = next_slot;
        row.reply.prev_slot  = prev_slot;
        return row;
    endfunction

    // applies one request to the image and returns the reply it should produce
    function automatic sched_reply_t schedule_step(input sched_req_t r);
        sched_reply_t res;
        logic [SUM_W-1:0] sum;
        logic [SUM_W-1:0] best_sum;
        int best;
        bit found;
        res.prev_slot = running;
        found    = 1'b0;
        best     = 0;
        best_sum = '0;
        case (r.cmd)
            CMD_TICK: begin
                // strict compare keeps the lowest index on ties
                for (int i = 0; i < SLOTS; i++) begin
                    sum = {1'b0, pri_tbl[i]} + {1'b0, age_tbl[i]};
                    if (st_tbl[i] != ST_WAITING && st_tbl[i] != ST_TERMINATED &&
                        (!found || sum > best_sum)) begin
                        found    = 1'b1;
                        best     = i;
                        best_sum = sum;
                    end
                end
                for (int i = 0; i < SLOTS; i++)
                    if (age_tbl[i] != AGE_MAX)
                        age_tbl[i] = age_tbl[i] + 1'b1;
                if (found) begin
                    // only an executing slot drops back to ready
                    if (st_tbl[running] == ST_EXECUTING)
                        st_tbl[running] = ST_READY;
                    age_tbl[best] = '0;
                    st_tbl[best]  = ST_EXECUTING;
                    running       = best[SLOT_W-1:0];
                end
            end
            CMD_SET_PRI: begin
                if (r.slot < SLOTS)
                    pri_tbl[r.slot] = r.pri;
            end
            CMD_SET_ST: begin
                if (r.slot < SLOTS && r.st <= ST_TERMINATED)
                    st_tbl[r.slot] = r.st;
            end
            default: ;
        endcase
        res.dispatched = found;
        res.next_slot  = found ? best[SLOT_W-1:0] : '0;
        return res;
    endfunction

    // statuses lean toward eligible ones so ticks usually have a choice
    function automatic sched_req_t random_request();
        sched_req_t r;
        int unsigned pick;
        r.slot = SLOT_W'($urandom_range(0, SLOTS - 1));
        pick = $urandom_range(0, 99);
        if (pick < 10)
            r.pri = '0;
        else if (pick < 20)
            r.pri = PRI_TOP;
        else
            r.pri = PRI_W'($urandom_range(0, 255));
        pick = $urandom_range(0, 99);
        if (pick < 15)
            r.st = ST_CREATED;
        else if (pick < 45)
            r.st = ST_READY;
        else if (pick < 55)
            r.st = ST_EXECUTING;
        else if (pick < 75)
            r.st = ST_WAITING;
        else if (pick < 90)
            r.st = ST_TERMINATED;
        else
            r.st = ST_W'($urandom_range(ST_BAD_LO, ST_BAD_HI));
        pick = $urandom_range(0, 99);
        if (pick < 40)
            r.cmd = CMD_TICK;
        else if (pick < 65)
            r.cmd = CMD_SET_PRI;
        else if (pick < 95)
            r.cmd = CMD_SET_ST;
        else
            r.cmd = CMD_UNUSED;
        return r;
    endfunction

    // offers one request, then records its reply once the block takes it
    task automatic issue_request(input sched_req_t r, input logic typed,
                                 input sched_reply_t reply);
        logic [IN_W-1:0] word;
        sched_reply_t predicted;
        int unsigned gap;
        word = '0;
        word[IN_BITS-1:0] = {r.st, r.pri, r.slot, r.cmd};
        s_axis_tdata  <= word;
        s_axis_tvalid <= 1'b1;
        @(posedge i_clk);
        while (!s_axis_tready)
            @(posedge i_clk);
        predicted = schedule_step(r);
        replies_due.push_back(typed ? reply : predicted);
        requests_taken++;
        // a run of back-to-back requests every 64
        gap = (requests_taken % 64 < 12) ? 0 : idle_len();
        if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // reply checker
    always @(posedge i_clk) begin
        sched_reply_t want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            replies_seen++;
            if (replies_due.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("reply %h arrived with nothing pending", m_axis_tdata);
            end else begin
                want = replies_due.pop_front();
                if (m_axis_tdata[0]   !== want.dispatched ||
                    m_axis_tdata[4:1] !== want.next_slot  ||
                    m_axis_tdata[8:5] !== want.prev_slot) begin
                    mismatches++;
                    if (mismatches <= REPORT_MAX)
                        $display({"reply %0d: expected dispatched=%0d next=%0d prev=%0d,",
                                  " got dispatched=%0d next=%0d prev=%0d"},
                                 replies_seen, want.dispatched, want.next_slot,
                                 want.prev_slot, m_axis_tdata[0], m_axis_tdata[4:1],
                                 m_axis_tdata[8:5]);
                end
            end
        end
    end

    // reply side: random stalls, calm stretches, and one long hold-off
    initial begin : sink
        int unsigned stall;
        bit squeezed;
        squeezed = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            m_axis_tready <= 1'b1;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
            if (!squeezed && replies_seen >= 60) begin
                // requests stay offered while nothing drains, and the block must hold them off
                squeezed = 1'b1;
                m_axis_tready <= 1'b0;
                repeat (SQUEEZE_CYCLES) @(posedge i_clk);
            end else begin
                stall = (cycle_count % 512 < 96) ? 0 : idle_len();
                if (stall != 0) begin
                    m_axis_tready <= 1'b0;
                    repeat (stall) @(posedge i_clk);
                end
            end
        end
    end

    initial begin : stimulus
        plan_row_t plan [$];

        for (int i = 0; i < SLOTS; i++) begin
            pri_tbl[i] = '0;
            age_tbl[i] = '0;
            st_tbl[i]  = ST_TERMINATED;
        end
        running = '0;

        // everything starts terminated, so nothing can run yet
        plan.push_back(known(CMD_TICK, 4'd0, 8'd0, ST_CREATED, 1'b0, 4'd0, 4'd0));
        plan.push_back(known(CMD_UNUSED, SLOT_LAST, PRI_TOP, ST_BAD_HI, 1'b0, 4'd0, 4'd0));
        // bad status codes are dropped
        plan.push_back(known(CMD_SET_ST, SLOT_LAST, 8'd0, ST_BAD_HI, 1'b0, 4'd0, 4'd0));
        plan.push_back(known(CMD_SET_ST, 4'd3, 8'd0, ST_BAD_LO, 1'b0, 4'd0, 4'd0));
        plan.push_back(known(CMD_SET_PRI, 4'd0, PRI_TOP, ST_CREATED, 1'b0, 4'd0, 4'd0));
        plan.push_back(known(CMD_SET_PRI, SLOT_LAST, PRI_TOP, ST_CREATED, 1'b0, 4'd0, 4'd0));
        plan.push_back(known(CMD_SET_ST, 4'd0, 8'd0, ST_CREATED, 1'b0, 4'd0, 4'd0));
        plan.push_back(known(CMD_SET_ST, SLOT_LAST, 8'd0, ST_READY, 1'b0, 4'd0, 4'd0));
        // equal sums at both ends, lowest index wins and is also the running slot
        plan.push_back(known(CMD_TICK, 4'd0, 8'd0, ST_CREATED, 1'b1, 4'd0, 4'd0));
        plan.push_back(checked(CMD_TICK, 4'd0, 8'd0, ST_CREATED));
        // running slot goes to waiting and must stay there
        plan.push_back(checked(CMD_SET_ST, SLOT_LAST, 8'd0, ST_WAITING));
        plan.push_back(checked(CMD_TICK, 4'd5, 8'd0, ST_CREATED));
        plan.push_back(checked(CMD_SET_PRI, 4'd8, 8'h5a, ST_CREATED));
        plan.push_back(checked(CMD_SET_ST, 4'd8, 8'd0, ST_EXECUTING));
        plan.push_back(checked(CMD_SET_PRI, 4'd7, 8'ha5, ST_CREATED));
        plan.push_back(checked(CMD_SET_ST, 4'd7, 8'd0, ST_READY));
        plan.push_back(checked(CMD_TICK, 4'd0, 8'd0, ST_CREATED));
        plan.push_back(checked(CMD_TICK, 4'd0, 8'd0, ST_CREATED));
        // running slot terminated before a tick keeps its terminated status
        plan.push_back(checked(CMD_SET_ST, 4'd0, 8'd0, ST_TERMINATED));
        plan.push_back(checked(CMD_TICK, 4'd0, 8'd0, ST_CREATED));
        // no eligible slot at all
        plan.push_back(checked(CMD_SET_ST, 4'd7, 8'd0, ST_WAITING));
        plan.push_back(checked(CMD_SET_ST, 4'd8, 8'd0, ST_TERMINATED));
        plan.push_back(checked(CMD_TICK, 4'd0, 8'd0, ST_CREATED));
        plan.push_back(checked(CMD_SET_ST, SLOT_LAST, 8'd0, ST_READY));
        plan.push_back(checked(CMD_TICK, 4'd0, 8'd0, ST_CREATED));

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (plan[k])
            issue_request(plan[k].req, plan[k].typed, plan[k].reply);

        repeat (MIXED_RUN)
            issue_request(random_request(), 1'b0, '0);

        // park the last slot long enough for its age to saturate, then release it
        issue_request(make_req(CMD_SET_PRI, SLOT_LAST, PRI_TOP, ST_CREATED), 1'b0, '0);
        issue_request(make_req(CMD_SET_ST, SLOT_LAST, 8'd0, ST_WAITING), 1'b0, '0);
        repeat (AGING_TICKS)
            issue_request(make_req(CMD_TICK, SLOT_W'($urandom_range(0, SLOTS - 1)),
                                   PRI_W'($urandom_range(0, 255)),
                                   ST_W'($urandom_range(0, 7))),
                          1'b0, '0);
        issue_request(make_req(CMD_SET_ST, SLOT_LAST, 8'd0, ST_READY), 1'b0, '0);
        issue_request(make_req(CMD_TICK, 4'd0, 8'd0, ST_CREATED), 1'b0, '0);

        repeat (MIXED_RUN)
            issue_request(random_request(), 1'b0, '0);

        s_axis_tvalid <= 1'b0;
        while (replies_due.size() != 0)
            @(posedge i_clk);
        // catch any stray reply after the last one
        repeat (TICK_LATENCY + 8) @(posedge i_clk);

        if (mismatches == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// File: filelist.f
rtl/core/aps_pkg.sv
rtl/core/aps_cell.sv
rtl/core/aging_priority_scheduler_top.sv
verif/testbench.sv
